// ===== hw/rtl/fgn_pkg.sv =====
// Shared types, constants and the gradient helper function for the fractal gradient noise block.
package fgn_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int MAX_OCTAVES = 8;
	localparam int OCT_W       = $clog2(MAX_OCTAVES);
	localparam int STEP_W      = 6;

	// register indexes on the configuration port
	localparam logic [1:0] REG_OCTAVE_COUNT     = 2'd0;
	localparam logic [1:0] REG_PERSISTENCE_GAIN = 2'd1;
	localparam logic [1:0] REG_BASE_AMPLITUDE   = 2'd2;
	localparam logic [1:0] REG_BASE_FREQUENCY   = 2'd3;

	localparam logic [3:0]  RST_OCTAVE_COUNT     = 4'd4;
	localparam logic [16:0] RST_PERSISTENCE_GAIN = 17'd32768;
	localparam logic [23:0] RST_BASE_AMPLITUDE   = 24'd65536;
	localparam logic [23:0] RST_BASE_FREQUENCY   = 24'd65536;

	// last step (or, for the fade phase, last axis) of each multi-step sequencer phase
	localparam logic [STEP_W-1:0] SCALE_LAST = 6'd2;
	localparam logic [STEP_W-1:0] FADE_LAST  = 6'd4;
	localparam logic [1:0]        AXIS_LAST  = 2'd2;
	localparam logic [STEP_W-1:0] HASH_LAST  = 6'd14;
	localparam logic [STEP_W-1:0] LERP_LAST  = 6'd6;
	localparam logic [STEP_W-1:0] DIV_LAST   = 6'd47;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_TWRITE,
		OP_SCALE,
		OP_SPLIT,
		OP_FADE,
		OP_HASH,
		OP_GRAD,
		OP_LDIFF,
		OP_LMUL,
		OP_ACC,
		OP_AMP,
		OP_DINIT,
		OP_DSTEP,
		OP_DDONE,
		OP_OUT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [STEP_W-1:0] arg;
		logic [OCT_W-1:0]  oct;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	typedef struct packed {
		logic [3:0]  octave_count;
		logic [16:0] persistence_gain;
		logic [23:0] base_amplitude;
		logic [23:0] base_frequency;
	} cfg_t;

	// improved noise gradient: picks two of x/y/z by hash and adds with signs
	function automatic logic signed [18:0] grad(input logic [3:0] h,
			input logic signed [17:0] x, input logic signed [17:0] y,
			input logic signed [17:0] z);
		logic signed [18:0] u;
		logic signed [18:0] v;
		u = (h < 4'd8) ? 19'(x) : 19'(y);
		if (h < 4'd4) begin
			v = 19'(y);
		end else if (h == 4'd12 || h == 4'd14) begin
			v = 19'(x);
		end else begin
			v = 19'(z);
		end
		if (h[0]) u = -u;
		if (h[1]) v = -v;
		return u + v;
	endfunction

endpackage

// ===== hw/rtl/fgn_ifs.sv =====
// Handshake channel interfaces: sample requests, noise results, configuration writes.
interface fgn_sample_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic [7:0]         entry_index;
	logic [7:0]         entry_value;
	modport source(output valid, operation, coord_x, coord_y, coord_z, entry_index,
		entry_value, input ready);
	modport sink(input valid, operation, coord_x, coord_y, coord_z, entry_index,
		entry_value, output ready);
endinterface

interface fgn_result_if;
	logic               valid;
	logic               ready;
	logic signed [17:0] noise_value;
	modport source(output valid, noise_value, input ready);
	modport sink(input valid, noise_value, output ready);
endinterface

interface fgn_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/fgn_ctrl.sv =====
// Sequencer that issues table writes and steps the datapath through scaling, octaves, the final divide and output.
module fgn_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_operation,
	output logic                     in_ready,
	input  logic [fgn_pkg::OCT_W-1:0] oct_last,
	input  fgn_pkg::status_t         status,
	output fgn_pkg::cmd_t            cmd
);
	import fgn_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_SCALE, S_SPLIT, S_FADE, S_HASH, S_GRAD, S_LDIFF, S_LMUL,
		S_ACC, S_AMP, S_DINIT, S_DSTEP, S_DDONE, S_FINISH
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic [1:0]        axis_q;
	logic [OCT_W-1:0]  oct_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.op  = OP_NONE;
		cmd.arg = step_q;
		cmd.oct = oct_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) cmd.op = in_operation ? OP_TWRITE : OP_LOAD;
			end
			S_SCALE:  cmd.op = OP_SCALE;
			S_SPLIT:  cmd.op = OP_SPLIT;
			S_FADE: begin
				cmd.op  = OP_FADE;
				cmd.arg = {1'b0, axis_q, step_q[2:0]};
			end
			S_HASH:   cmd.op = OP_HASH;
			S_GRAD:   cmd.op = OP_GRAD;
			S_LDIFF:  cmd.op = OP_LDIFF;
			S_LMUL:   cmd.op = OP_LMUL;
			S_ACC:    cmd.op = OP_ACC;
			S_AMP:    cmd.op = OP_AMP;
			S_DINIT:  cmd.op = OP_DINIT;
			S_DSTEP:  cmd.op = OP_DSTEP;
			S_DDONE:  cmd.op = OP_DDONE;
			S_FINISH: begin
				if (!status.out_busy) cmd.op = OP_OUT;
			end
			default:  cmd.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			axis_q  <= '0;
			oct_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					step_q <= '0;
					axis_q <= '0;
					oct_q  <= '0;
					if (in_valid && !in_operation) state_q <= S_SCALE;
				end
				S_SCALE: begin
					if (step_q == SCALE_LAST) begin
						step_q  <= '0;
						state_q <= S_SPLIT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_SPLIT: begin
					step_q  <= '0;
					axis_q  <= '0;
					state_q <= S_FADE;
				end
				S_FADE: begin
					if (step_q == FADE_LAST) begin
						step_q <= '0;
						if (axis_q == AXIS_LAST) begin
							state_q <= S_HASH;
						end else begin
							axis_q <= axis_q + 1'b1;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_HASH: begin
					if (step_q == HASH_LAST) begin
						step_q  <= '0;
						state_q <= S_GRAD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_GRAD:  state_q <= S_LDIFF;
				S_LDIFF: state_q <= S_LMUL;
				S_LMUL: begin
					if (step_q == LERP_LAST) begin
						step_q  <= '0;
						state_q <= S_ACC;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= S_LDIFF;
					end
				end
				S_ACC: state_q <= S_AMP;
				S_AMP: begin
					if (oct_q == oct_last) begin
						state_q <= S_DINIT;
					end else begin
						oct_q   <= oct_q + 1'b1;
						state_q <= S_SPLIT;
					end
				end
				S_DINIT: begin
					step_q  <= '0;
					state_q <= S_DSTEP;
				end
				S_DSTEP: begin
					if (step_q == DIV_LAST) begin
						step_q  <= '0;
						state_q <= S_DDONE;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				S_DDONE: state_q <= S_FINISH;
				S_FINISH: begin
					if (!status.out_busy) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hw/rtl/fgn_datapath.sv =====
// Noise datapath: shared multiplier, permutation memory, lerp tree, accumulator, divider.
module fgn_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  fgn_pkg::cmd_t      cmd,
	input  fgn_pkg::cfg_t      cfg,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [7:0]         entry_index,
	input  logic [7:0]         entry_value,
	output fgn_pkg::status_t   status,
	fgn_result_if.source       results
);
	import fgn_pkg::*;

	localparam logic signed [25:0] FADE_C15 = 26'sd983040;
	localparam logic signed [25:0] FADE_C10 = 26'sd655360;
	localparam logic signed [17:0] ONE_Q    = 18'sd65536;
	localparam logic [23:0]        AMP_MAX  = 24'hFFFFFF;

	// sample registers
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [39:0]        px_q, py_q, pz_q;
	logic [7:0]         cell_x_q, cell_y_q, cell_z_q;
	logic [15:0]        fx_q, fy_q, fz_q;
	logic signed [25:0] r_q;
	logic signed [16:0] fu_q, fv_q, fw_q;
	logic [7:0]         ha_q, hb_q, haa_q, hab_q, hba_q, hbb_q;
	logic [7:0]         hg_q [8];
	logic signed [19:0] lv_q [8];
	logic signed [19:0] lerp_a_q;
	logic signed [20:0] lerp_d_q;
	logic signed [16:0] lerp_t_q;
	logic [23:0]        amp_q;
	logic [27:0]        sum_q;
	logic signed [47:0] total_q;
	logic [47:0]        dq_q;
	logic [28:0]        rem_q;
	logic               neg_q;
	logic signed [17:0] res_q;
	logic               out_valid_q;
	logic signed [17:0] noise_q;

	// permutation memory with per-entry valid bits; an unwritten entry reads as its index
	logic [7:0] mem [256];
	logic [255:0] vld_q;
	logic [7:0] rd_addr;
	logic [7:0] rd_data_q, rd_addr_q;
	logic       rd_vld_q;
	logic [7:0] rd_val;

	always_ff @(posedge clk) begin
		if (cmd.op == OP_TWRITE) mem[entry_index] <= entry_value;
		rd_data_q <= mem[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
		rd_addr_q <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.op == OP_TWRITE) begin
			vld_q[entry_index] <= 1'b1;
		end
	end

	assign rd_val = rd_vld_q ? rd_data_q : rd_addr_q;

	always_comb begin
		rd_addr = '0;
		if (cmd.op == OP_HASH) begin
			case (cmd.arg)
				6'd0:    rd_addr = cell_x_q;
				6'd1:    rd_addr = cell_x_q + 8'd1;
				6'd2:    rd_addr = ha_q;
				6'd3:    rd_addr = ha_q + 8'd1;
				6'd4:    rd_addr = hb_q;
				6'd5:    rd_addr = hb_q + 8'd1;
				6'd6:    rd_addr = haa_q;
				6'd7:    rd_addr = hba_q;
				6'd8:    rd_addr = hab_q;
				6'd9:    rd_addr = hbb_q;
				6'd10:   rd_addr = haa_q + 8'd1;
				6'd11:   rd_addr = hba_q + 8'd1;
				6'd12:   rd_addr = hab_q + 8'd1;
				6'd13:   rd_addr = hbb_q + 8'd1;
				default: rd_addr = '0;
			endcase
		end
	end

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [24:0] mul_b;
	logic signed [57:0] prod;
	logic signed [57:0] prod_sh;
	logic [15:0]        fade_t;

	always_comb begin
		case (cmd.arg[4:3])
			2'd0:    fade_t = fx_q;
			2'd1:    fade_t = fy_q;
			default: fade_t = fz_q;
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SCALE: begin
				case (cmd.arg[1:0])
					2'd0:    mul_a = 33'(cx_q);
					2'd1:    mul_a = 33'(cy_q);
					default: mul_a = 33'(cz_q);
				endcase
				mul_b = {1'b0, cfg.base_frequency};
			end
			OP_FADE: begin
				mul_a = 33'(r_q);
				mul_b = {9'b0, fade_t};
			end
			OP_LMUL: begin
				mul_a = 33'(lerp_d_q);
				mul_b = 25'(lerp_t_q);
			end
			OP_ACC: begin
				mul_a = 33'(lv_q[0]);
				mul_b = {1'b0, amp_q};
			end
			OP_AMP: begin
				mul_a = {9'b0, amp_q};
				mul_b = {8'b0, cfg.persistence_gain};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign prod_sh = prod >>> FRAC_BITS;

	// scaled coordinate shifted up by the octave index
	logic [39:0] shx, shy, shz;
	assign shx = px_q << cmd.oct;
	assign shy = py_q << cmd.oct;
	assign shz = pz_q << cmd.oct;

	logic signed [25:0] fade_tt;
	logic signed [25:0] fade_r0;
	assign fade_tt = 26'({10'b0, fade_t});
	assign fade_r0 = (fade_tt <<< 2) + (fade_tt <<< 1) - FADE_C15;

	// corner offsets for the gradients
	logic signed [17:0] x0, y0, z0, x1, y1, z1;
	assign x0 = 18'({2'b0, fx_q});
	assign y0 = 18'({2'b0, fy_q});
	assign z0 = 18'({2'b0, fz_q});
	assign x1 = x0 - ONE_Q;
	assign y1 = y0 - ONE_Q;
	assign z1 = z0 - ONE_Q;

	// lerp operand selection
	logic signed [19:0] la, lb;
	logic signed [16:0] lt;
	always_comb begin
		case (cmd.arg)
			6'd0:    begin la = lv_q[0]; lb = lv_q[1]; lt = fu_q; end
			6'd1:    begin la = lv_q[2]; lb = lv_q[3]; lt = fu_q; end
			6'd2:    begin la = lv_q[4]; lb = lv_q[5]; lt = fu_q; end
			6'd3:    begin la = lv_q[6]; lb = lv_q[7]; lt = fu_q; end
			6'd4:    begin la = lv_q[0]; lb = lv_q[2]; lt = fv_q; end
			6'd5:    begin la = lv_q[4]; lb = lv_q[6]; lt = fv_q; end
			default: begin la = lv_q[0]; lb = lv_q[4]; lt = fw_q; end
		endcase
	end

	logic signed [19:0] lerp_res;
	assign lerp_res = lerp_a_q + prod_sh[19:0];

	// divider step and final saturation
	logic [28:0] rem_sh;
	logic [16:0] q_sat;
	assign rem_sh = {rem_q[27:0], dq_q[47]};
	assign q_sat  = (dq_q > 48'd65536) ? 17'd65536 : dq_q[16:0];

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				cx_q    <= coord_x;
				cy_q    <= coord_y;
				cz_q    <= coord_z;
				amp_q   <= cfg.base_amplitude;
				sum_q   <= '0;
				total_q <= '0;
			end
			OP_SCALE: begin
				case (cmd.arg[1:0])
					2'd0:    px_q <= prod[39:0];
					2'd1:    py_q <= prod[39:0];
					default: pz_q <= prod[39:0];
				endcase
			end
			OP_SPLIT: begin
				cell_x_q <= shx[39:32];
				cell_y_q <= shy[39:32];
				cell_z_q <= shz[39:32];
				fx_q     <= shx[31:16];
				fy_q     <= shy[31:16];
				fz_q     <= shz[31:16];
			end
			OP_FADE: begin
				case (cmd.arg[2:0])
					3'd0:    r_q <= fade_r0;
					3'd1:    r_q <= prod_sh[25:0] + FADE_C10;
					3'd2,
					3'd3:    r_q <= prod_sh[25:0];
					default: begin
						case (cmd.arg[4:3])
							2'd0:    fu_q <= prod_sh[16:0];
							2'd1:    fv_q <= prod_sh[16:0];
							default: fw_q <= prod_sh[16:0];
						endcase
					end
				endcase
			end
			OP_HASH: begin
				case (cmd.arg)
					6'd1:    ha_q  <= rd_val + cell_y_q;
					6'd2:    hb_q  <= rd_val + cell_y_q;
					6'd3:    haa_q <= rd_val + cell_z_q;
					6'd4:    hab_q <= rd_val + cell_z_q;
					6'd5:    hba_q <= rd_val + cell_z_q;
					6'd6:    hbb_q <= rd_val + cell_z_q;
					6'd7:    hg_q[0] <= rd_val;
					6'd8:    hg_q[1] <= rd_val;
					6'd9:    hg_q[2] <= rd_val;
					6'd10:   hg_q[3] <= rd_val;
					6'd11:   hg_q[4] <= rd_val;
					6'd12:   hg_q[5] <= rd_val;
					6'd13:   hg_q[6] <= rd_val;
					6'd14:   hg_q[7] <= rd_val;
					default: ;
				endcase
			end
			OP_GRAD: begin
				for (int g = 0; g < 8; g++) begin
					lv_q[g] <= 20'(grad(hg_q[g][3:0],
						g[0] ? x1 : x0, g[1] ? y1 : y0, g[2] ? z1 : z0));
				end
			end
			OP_LDIFF: begin
				lerp_a_q <= la;
				lerp_d_q <= 21'(lb) - 21'(la);
				lerp_t_q <= lt;
			end
			OP_LMUL: begin
				case (cmd.arg)
					6'd0, 6'd4, 6'd6: lv_q[0] <= lerp_res;
					6'd1:             lv_q[2] <= lerp_res;
					6'd2, 6'd5:       lv_q[4] <= lerp_res;
					default:          lv_q[6] <= lerp_res;
				endcase
			end
			OP_ACC: begin
				total_q <= total_q + prod[47:0];
				sum_q   <= sum_q + 28'(amp_q);
			end
			OP_AMP: begin
				if (prod_sh[57:24] != '0) begin
					amp_q <= AMP_MAX;
				end else begin
					amp_q <= prod_sh[23:0];
				end
			end
			OP_DINIT: begin
				neg_q <= total_q[47];
				dq_q  <= total_q[47] ? 48'(-total_q) : 48'(total_q);
				rem_q <= '0;
			end
			OP_DSTEP: begin
				if (rem_sh >= {1'b0, sum_q}) begin
					rem_q <= rem_sh - {1'b0, sum_q};
					dq_q  <= {dq_q[46:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					dq_q  <= {dq_q[46:0], 1'b0};
				end
			end
			OP_DDONE: begin
				if (sum_q == '0) begin
					res_q <= '0;
				end else if (neg_q) begin
					res_q <= -18'($signed({1'b0, q_sat}));
				end else begin
					res_q <= 18'($signed({1'b0, q_sat}));
				end
			end
			OP_OUT:  noise_q <= res_q;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.op == OP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.noise_value = noise_q;
	assign status.out_busy     = out_valid_q && !results.ready;

endmodule

// ===== hw/rtl/fractal_gradient_noise_3d.sv =====
// Top level of the fractal 3D gradient noise block: config registers, sequencer, datapath.
//
// Channels: samples (sink) takes sample requests (operation 0) and permutation
// table loads (operation 1); results (source) returns one noise_value per sample
// request, none per load; cfg (sink) writes the four registers, always ready.
// A load request is written into the table while the block stays ready. A
// sample request runs on one shared multiplier and one permutation memory
// read port, octave by octave through fade, hashing and the lerp tree, then
// a 48-step restoring divide. The block is ready for the next request in the
// same cycle as the result appears.
// The result sits in an output register; while it is not taken the block
// still accepts and works on the next request, and holds that one's result
// until the register frees up.
// Reset (arst_n low) sets the registers to their defaults and marks every
// permutation entry unwritten, so the table reads as the identity at once.
module fractal_gradient_noise_3d (
	input  logic         clk,
	input  logic         arst_n,
	fgn_sample_if.sink   samples,
	fgn_result_if.source results,
	fgn_cfg_if.sink      cfg
);
	import fgn_pkg::*;

	cfg_t             cfg_q;
	cmd_t             cmd;
	status_t          status;
	logic [OCT_W-1:0] oct_last;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.octave_count     <= RST_OCTAVE_COUNT;
			cfg_q.persistence_gain <= RST_PERSISTENCE_GAIN;
			cfg_q.base_amplitude   <= RST_BASE_AMPLITUDE;
			cfg_q.base_frequency   <= RST_BASE_FREQUENCY;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_OCTAVE_COUNT:     cfg_q.octave_count     <= cfg.data[3:0];
				REG_PERSISTENCE_GAIN: cfg_q.persistence_gain <= cfg.data[16:0];
				REG_BASE_AMPLITUDE:   cfg_q.base_amplitude   <= cfg.data;
				REG_BASE_FREQUENCY:   cfg_q.base_frequency   <= cfg.data;
				default: ;
			endcase
		end
	end

	// zero counts as one octave, anything above the limit is clamped
	always_comb begin
		if (cfg_q.octave_count == 4'd0) begin
			oct_last = '0;
		end else if (cfg_q.octave_count > 4'(MAX_OCTAVES)) begin
			oct_last = OCT_W'(MAX_OCTAVES - 1);
		end else begin
			oct_last = OCT_W'(cfg_q.octave_count - 4'd1);
		end
	end

	fgn_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (samples.valid),
		.in_operation (samples.operation),
		.in_ready     (samples.ready),
		.oct_last     (oct_last),
		.status       (status),
		.cmd          (cmd)
	);

	fgn_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.coord_x     (samples.coord_x),
		.coord_y     (samples.coord_y),
		.coord_z     (samples.coord_z),
		.entry_index (samples.entry_index),
		.entry_value (samples.entry_value),
		.status      (status),
		.results     (results)
	);

endmodule

// ===== hw/rtl/fgn_checker.sv =====
// Port-level checker for the fractal noise block and its bind to the top level.
module fgn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               in_operation,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [17:0] noise_value
);

	// a result waiting for the receiver stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(noise_value))
		else $error("result changed while stalled");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (noise_value <= 18'sd65536 && noise_value >= -18'sd65536))
		else $error("noise value outside plus or minus one");

	// a sample request keeps the block busy for the following cycle
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_operation |=> !in_ready)
		else $error("request accepted during sample processing");

	// a new result only ever comes out of the busy phase
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a running sample");

endmodule

bind fractal_gradient_noise_3d fgn_checker u_fgn_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (samples.valid),
	.in_ready     (samples.ready),
	.in_operation (samples.operation),
	.out_valid    (results.valid),
	.out_ready    (results.ready),
	.noise_value  (results.noise_value)
);

// ===== verif/fractal_gradient_noise_3d_tb.sv =====
// Testbench for fractal_gradient_noise_3d: random and directed requests checked against a predictor.
`timescale 1ns / 1ps

module fractal_gradient_noise_3d_tb;
	import fgn_pkg::*;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_PERM   = 1'b1;

	typedef struct {
		logic        operation;
		logic [31:0] cx;
		logic [31:0] cy;
		logic [31:0] cz;
		logic [7:0]  idx;
		logic [7:0]  val;
	} req_t;

	logic clk;
	logic arst_n;

	fgn_sample_if samples();
	fgn_result_if results();
	fgn_cfg_if    cfg();

	fractal_gradient_noise_3d dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results),
		.cfg(cfg)
	);

	// predictor state
	logic [7:0]  perm_tbl [256];
	logic [3:0]  octaves;
	logic [16:0] gain;
	logic [23:0] base_amp;
	logic [23:0] base_freq;

	req_t                req_q[$];
	logic signed [17:0]  noise_exp_q[$];
	int                  mismatches = 0;
	int unsigned         sent_cnt = 0;
	int unsigned         taken_cnt = 0;
	int                  send_gap = 0;
	int                  recv_gap = 0;
	int                  hold_left = 0;
	bit                  idling_on = 1;
	bit                  hold_req = 0;
	bit                  hold_done = 0;

	initial begin
		clk = 1'b0;
	end
	always #1 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic longint fade16(input longint t);
		longint r;
		r = 6 * t - 15 * 65536;
		r = ((t * r) >>> 16) + 10 * 65536;
		r = (t * r) >>> 16;
		r = (t * r) >>> 16;
		return (t * r) >>> 16;
	endfunction

	function automatic longint lerp16(input longint t, input longint a, input longint b);
		return a + ((t * (b - a)) >>> 16);
	endfunction

	function automatic longint grad_dot(input logic [7:0] hv, input longint x,
			input longint y, input longint z);
		logic [3:0] h;
		longint u;
		longint v;
		h = hv[3:0];
		u = (h < 8) ? x : y;
		v = (h < 4) ? y : ((h == 12 || h == 14) ? x : z);
		return (h[0] ? -u : u) + (h[1] ? -v : v);
	endfunction

	function automatic logic [7:0] pt(input int i);
		return perm_tbl[i[7:0]];
	endfunction

	function automatic longint octave_noise(input req_t r, input longint freq);
		logic [31:0] c [3];
		logic [63:0] p;
		int     cell_idx [3];
		longint f [3];
		longint fd [3];
		longint f1 [3];
		int A, B, AA, AB, BA, BB;
		c[0] = r.cx;
		c[1] = r.cy;
		c[2] = r.cz;
		for (int k = 0; k < 3; k++) begin
			p = longint'($signed(c[k])) * freq;
			cell_idx[k] = int'(p[39:32]);
			f[k] = longint'(p[31:16]);
			fd[k] = fade16(f[k]);
			f1[k] = f[k] - 65536;
		end
		A  = (pt(cell_idx[0]) + cell_idx[1]) & 255;
		B  = (pt(cell_idx[0] + 1) + cell_idx[1]) & 255;
		AA = (pt(A) + cell_idx[2]) & 255;
		AB = (pt(A + 1) + cell_idx[2]) & 255;
		BA = (pt(B) + cell_idx[2]) & 255;
		BB = (pt(B + 1) + cell_idx[2]) & 255;
		return lerp16(fd[2],
			lerp16(fd[1],
				lerp16(fd[0], grad_dot(pt(AA), f[0], f[1], f[2]),
					grad_dot(pt(BA), f1[0], f[1], f[2])),
				lerp16(fd[0], grad_dot(pt(AB), f[0], f1[1], f[2]),
					grad_dot(pt(BB), f1[0], f1[1], f[2]))),
			lerp16(fd[1],
				lerp16(fd[0], grad_dot(pt(AA + 1), f[0], f[1], f1[2]),
					grad_dot(pt(BA + 1), f1[0], f[1], f1[2])),
				lerp16(fd[0], grad_dot(pt(AB + 1), f[0], f1[1], f1[2]),
					grad_dot(pt(BB + 1), f1[0], f1[1], f1[2]))));
	endfunction

	function automatic logic signed [17:0] fractal_noise(input req_t r);
		int     n;
		longint amp;
		longint sum_amp;
		longint total;
		longint q;
		n = (octaves == 0) ? 1 : ((octaves > MAX_OCTAVES) ? MAX_OCTAVES : octaves);
		amp = base_amp;
		sum_amp = 0;
		total = 0;
		for (int i = 0; i < n; i++) begin
			total += octave_noise(r, longint'(base_freq) << i) * amp;
			sum_amp += amp;
			amp = (amp * gain) >> 16;
			if (amp > 16777215) amp = 16777215;
		end
		if (sum_amp == 0) begin
			q = 0;
		end else begin
			q = total / sum_amp;
			if (q > 65536) q = 65536;
			if (q < -65536) q = -65536;
		end
		return q[17:0];
	endfunction

	// request driver
	always @(negedge clk) begin
		if (!(samples.valid && taken_cnt != sent_cnt)) begin
			if (send_gap > 0) begin
				send_gap--;
				samples.valid <= 1'b0;
			end else if (arst_n && req_q.size() > 0) begin
				req_t r;
				r = req_q.pop_front();
				samples.operation <= r.operation;
				samples.coord_x <= r.cx;
				samples.coord_y <= r.cy;
				samples.coord_z <= r.cz;
				samples.entry_index <= r.idx;
				samples.entry_value <= r.val;
				samples.valid <= 1'b1;
				sent_cnt++;
				if (idling_on && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 16);
			end else begin
				samples.valid <= 1'b0;
			end
		end
	end

	// result receiver, with bursts of stall and one long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			results.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap--;
			results.ready <= 1'b0;
		end else begin
			results.ready <= 1'b1;
			if (idling_on && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 16);
		end
	end

	// monitor: shadow config, predict on accepted request, check results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 256; i++) perm_tbl[i] = i[7:0];
			octaves = RST_OCTAVE_COUNT;
			gain = RST_PERSISTENCE_GAIN;
			base_amp = RST_BASE_AMPLITUDE;
			base_freq = RST_BASE_FREQUENCY;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_OCTAVE_COUNT: octaves = cfg.data[3:0];
					REG_PERSISTENCE_GAIN: gain = cfg.data[16:0];
					REG_BASE_AMPLITUDE: base_amp = cfg.data;
					REG_BASE_FREQUENCY: base_freq = cfg.data;
					default: ;
				endcase
			end
			if (results.valid && results.ready) begin
				if (noise_exp_q.size() == 0) begin
					report_mismatch($sformatf("unexpected noise_value %0d",
						results.noise_value));
				end else begin
					logic signed [17:0] e;
					e = noise_exp_q.pop_front();
					if (results.noise_value !== e)
						report_mismatch($sformatf("noise_value %0d, expected %0d",
							results.noise_value, e));
				end
			end
			if (samples.valid && samples.ready) begin
				req_t r;
				taken_cnt++;
				r.operation = samples.operation;
				r.cx = samples.coord_x;
				r.cy = samples.coord_y;
				r.cz = samples.coord_z;
				r.idx = samples.entry_index;
				r.val = samples.entry_value;
				if (r.operation == OP_PERM) perm_tbl[r.idx] = r.val;
				else noise_exp_q.push_back(fractal_noise(r));
			end
		end
	end

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 2 * 65536 * 16) - 65536 * 16;
			2: return {16'($urandom_range(0, 65535)), 16'h0000};
			default: return $urandom_range(0, 65536 * 600);
		endcase
	endfunction

	task automatic push_sample(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		req_t r;
		r.operation = OP_SAMPLE;
		r.cx = x;
		r.cy = y;
		r.cz = z;
		r.idx = 8'($urandom());
		r.val = 8'($urandom());
		req_q.push_back(r);
	endtask

	task automatic push_perm(input logic [7:0] i, input logic [7:0] v);
		req_t r;
		r.operation = OP_PERM;
		r.cx = $urandom();
		r.cy = $urandom();
		r.cz = $urandom();
		r.idx = i;
		r.val = v;
		req_q.push_back(r);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 3) push_perm(8'($urandom()), 8'($urandom()));
			else push_sample(rand_coord(), rand_coord(), rand_coord());
		end
	endtask

	// a request popped by the driver in this same step still counts as in flight
	task automatic drain();
		while (req_q.size() > 0 || samples.valid || sent_cnt != taken_cnt ||
				noise_exp_q.size() > 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] i, input logic [23:0] d);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= i;
		cfg.data <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic set_cfg(input logic [3:0] oc, input logic [16:0] g,
			input logic [23:0] a, input logic [23:0] f);
		write_reg(REG_OCTAVE_COUNT, 24'(oc));
		write_reg(REG_PERSISTENCE_GAIN, 24'(g));
		write_reg(REG_BASE_AMPLITUDE, a);
		write_reg(REG_BASE_FREQUENCY, f);
	endtask

	initial begin
		arst_n = 1'b0;
		samples.valid = 1'b0;
		samples.operation = OP_SAMPLE;
		samples.coord_x = '0;
		samples.coord_y = '0;
		samples.coord_z = '0;
		samples.entry_index = '0;
		samples.entry_value = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_OCTAVE_COUNT;
		cfg.data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: coordinate extremes on the identity table, then table edges
		push_sample(32'h0, 32'h0, 32'h0);
		push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		push_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push_sample(32'hFFFF_FFFF, 32'h0000_8000, 32'h8000_0000);
		push_sample(32'h0000_FFFF, 32'hFFFF_0001, 32'h00FF_8000);
		push_perm(8'd0, 8'd255);
		push_perm(8'd255, 8'd0);
		push_perm(8'd1, 8'd128);
		push_sample(32'h0, 32'h0, 32'h0);
		push_sample(32'h00FF_C000, 32'h00FF_4000, 32'h0000_4000);
		push_sample(32'hFFFF_8000, 32'hFFFF_8000, 32'hFFFF_8000);
		drain();

		// zero octaves acts as one, large gain saturates the amplitude
		set_cfg(4'd0, 17'd131071, 24'd16777215, 24'd16777215);
		push_sample(32'h7FFF_FFFF, 32'h1234_5678, 32'h8000_0000);
		push_random(20);
		drain();
		set_cfg(4'd15, 17'd131071, 24'd16777215, 24'd1);
		push_sample(32'h0001_8000, 32'hFFFE_8000, 32'h4000_0000);
		push_random(30);
		drain();
		// zero base amplitude gives zero
		set_cfg(4'd3, 17'd65536, 24'd0, 24'd65536);
		push_sample(32'h0001_8000, 32'h0002_4000, 32'h0003_2000);
		push_random(20);
		drain();
		set_cfg(4'd1, 17'd0, 24'd1, 24'd16777215);
		push_random(300);
		hold_req = 1;
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_cfg(4'($urandom_range(1, 3)), 17'($urandom_range(0, 131071)),
				24'($urandom_range(1, 16777215)), 24'($urandom_range(1, 300000)));
			push_random(130);
			drain();
		end
		set_cfg(4'd8, 17'd65536, 24'd65536, 24'd16384);
		push_random(60);
		drain();

		// final stretch without idling on either side
		set_cfg(4'd2, 17'd40000, 24'd300000, 24'd90000);
		idling_on = 0;
		push_random(300);
		drain();
		repeat (500) @(negedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("Mismatches found");
		$finish;
	end

endmodule
